// ===== rtl/skf_pkg.sv =====
// shared constants, types and saturation helpers for the scalar kalman filter
// no dependencies; used by every module of the block
`default_nettype none

package skf_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int COV_W     = 31;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int M_W       = PROD_W - FRAC_BITS;
	localparam int OUT_W     = 8 * ((DATA_W + COV_W + 7) / 8);
	localparam int CFG_IDX_W = 3;

	localparam int DIGIT_W   = 4;
	localparam int MUL_STEPS = DATA_W / DIGIT_W;
	localparam int MUL_CNT_W = $clog2(MUL_STEPS);
	localparam int HI_W      = DATA_W + DIGIT_W + 2;

	localparam int DIV_W     = DATA_W + FRAC_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam logic [HI_W-1:0]          MUL_RND = HI_W'(64'd1 << (FRAC_BITS - 1));
	localparam logic signed [PROD_W-1:0] ONE_P   = PROD_W'(64'd1 << FRAC_BITS);
	localparam logic signed [DATA_W-1:0] S_MAX   = {1'b0, {(DATA_W - 1){1'b1}}};
	localparam logic signed [DATA_W-1:0] S_MIN   = {1'b1, {(DATA_W - 1){1'b0}}};

	localparam logic signed [DATA_W-1:0] RST_TRANSITION  = DATA_W'(65536);
	localparam logic signed [DATA_W-1:0] RST_CONTROL     = DATA_W'(65536);
	localparam logic signed [DATA_W-1:0] RST_INPUT       = DATA_W'(0);
	localparam logic [COV_W-1:0]         RST_PROC_NOISE  = COV_W'(655);
	localparam logic signed [DATA_W-1:0] RST_OBSERVATION = DATA_W'(65536);
	localparam logic [COV_W-1:0]         RST_MEAS_NOISE  = COV_W'(6554);
	localparam logic signed [DATA_W-1:0] RST_ESTIMATE    = DATA_W'(0);
	localparam logic [COV_W-1:0]         RST_COVARIANCE  = COV_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRANSITION,
		REG_CONTROL,
		REG_INPUT,
		REG_PROC_NOISE,
		REG_OBSERVATION,
		REG_MEAS_NOISE,
		REG_INIT_EST,
		REG_INIT_COV
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MSTART,
		ST_MWAIT,
		ST_COMB,
		ST_DSTART,
		ST_DWAIT,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		STEP_AX,
		STEP_BU,
		STEP_AP,
		STEP_TA,
		STEP_PC,
		STEP_CP,
		STEP_CPC,
		STEP_CZ,
		STEP_CX,
		STEP_KI,
		STEP_KC,
		STEP_GP
	} step_t;

	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-DATA_W:0] upper;
		upper = v[PROD_W-1:DATA_W-1];
		if ((&upper) || !(|upper)) begin
			return v[DATA_W-1:0];
		end
		return v[PROD_W-1] ? S_MIN : S_MAX;
	endfunction

	function automatic logic signed [PROD_W-1:0] sext(input logic signed [DATA_W-1:0] v);
		return {{(PROD_W - DATA_W){v[DATA_W-1]}}, v};
	endfunction

endpackage

`default_nettype wire

// ===== rtl/skf_mul.sv =====
// digit-serial signed multiplier, 4 bits of the second operand per cycle
// product carries the fixed-point rounding constant; uses skf_pkg
`default_nettype none

module skf_mul (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [skf_pkg::DATA_W-1:0] a,
	input  wire logic signed [skf_pkg::DATA_W-1:0] b,
	output logic                                   done,
	output logic        [skf_pkg::PROD_W-1:0]      prod
);

	logic                                busy_q;
	logic [skf_pkg::MUL_CNT_W-1:0]       cnt_q;
	logic signed [skf_pkg::DATA_W-1:0]   a_q;
	logic [skf_pkg::DATA_W-1:0]          b_q;
	logic signed [skf_pkg::HI_W-1:0]     hi_q;
	logic [skf_pkg::DATA_W-1:0]          lo_q;

	logic                                last;
	logic signed [skf_pkg::DIGIT_W:0]    dig;
	logic signed [skf_pkg::DATA_W+skf_pkg::DIGIT_W:0] dprod;
	logic signed [skf_pkg::HI_W-1:0]     sum;

	assign last = (cnt_q == skf_pkg::MUL_CNT_W'(skf_pkg::MUL_STEPS - 1));
	assign done = busy_q && last;

	always_comb begin
		// top digit is signed, the others unsigned
		dig   = {last & b_q[skf_pkg::DIGIT_W-1], b_q[skf_pkg::DIGIT_W-1:0]};
		dprod = dig * a_q;
		sum   = hi_q + {{(skf_pkg::HI_W - skf_pkg::DATA_W - skf_pkg::DIGIT_W - 1)
			{dprod[skf_pkg::DATA_W+skf_pkg::DIGIT_W]}}, dprod};
	end

	assign prod = {hi_q[skf_pkg::DATA_W-1:0], lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= b;
			hi_q <= skf_pkg::MUL_RND;
			lo_q <= '0;
		end else if (busy_q) begin
			b_q  <= b_q >> skf_pkg::DIGIT_W;
			hi_q <= sum >>> skf_pkg::DIGIT_W;
			lo_q <= {sum[skf_pkg::DIGIT_W-1:0], lo_q[skf_pkg::DATA_W-1:skf_pkg::DIGIT_W]};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/skf_div.sv =====
// restoring divider for the kalman gain, one quotient bit per cycle
// rounds to nearest, saturates to the signed data range; uses skf_pkg
`default_nettype none

module skf_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [skf_pkg::DATA_W-1:0] num,
	input  wire logic signed [skf_pkg::DATA_W-1:0] den,
	output logic                                   done,
	output logic signed [skf_pkg::DATA_W-1:0]      quo
);

	logic                          busy_q;
	logic [skf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [skf_pkg::DIV_W-1:0]     dvd_q;
	logic [skf_pkg::COV_W-1:0]     rem_q;
	logic [skf_pkg::COV_W-1:0]     d_q;
	logic                          neg_q;
	logic                          zero_q;

	logic [skf_pkg::DATA_W-1:0]    mag_in;
	logic [skf_pkg::COV_W-1:0]     d_in;
	logic [skf_pkg::COV_W:0]       trial;
	logic                          ge;
	logic                          big;
	logic [skf_pkg::DATA_W-1:0]    mag;

	assign done = busy_q && (cnt_q == skf_pkg::DIV_CNT_W'(skf_pkg::DIV_W - 1));

	always_comb begin
		mag_in = num[skf_pkg::DATA_W-1] ? skf_pkg::DATA_W'(-num) : num;
		d_in   = den[skf_pkg::COV_W-1:0];
		trial  = {rem_q, dvd_q[skf_pkg::DIV_W-1]};
		ge     = (trial >= {1'b0, d_q});
		big    = |dvd_q[skf_pkg::DIV_W-1:skf_pkg::DATA_W-1];
		mag    = dvd_q[skf_pkg::DATA_W-1:0];
		if (zero_q) begin
			quo = '0;
		end else if (neg_q) begin
			quo = big ? skf_pkg::S_MIN : skf_pkg::DATA_W'(-mag);
		end else begin
			quo = big ? skf_pkg::S_MAX : mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// dividend is |num| scaled up, plus half the divisor for rounding
			dvd_q  <= {mag_in, {skf_pkg::FRAC_BITS{1'b0}}}
				+ skf_pkg::DIV_W'(d_in >> 1);
			rem_q  <= '0;
			d_q    <= d_in;
			neg_q  <= num[skf_pkg::DATA_W-1];
			zero_q <= den[skf_pkg::DATA_W-1] || (den == '0);
		end else if (busy_q) begin
			rem_q <= ge ? skf_pkg::COV_W'(trial - {1'b0, d_q}) : trial[skf_pkg::COV_W-1:0];
			dvd_q <= {dvd_q[skf_pkg::DIV_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/scalar_kalman_filter_unit.sv =====
// One-dimensional Kalman filter, signed Q16.16, with a stream input of
// measurements and a stream output of estimate and covariance words. One
// measurement is processed at a time: twelve products go through the 4-bit
// digit-serial multiplier, and the gain through the 48-step restoring
// divider. The result is held in an output register, so the next
// measurement is taken while it waits. Writing the initial estimate or
// covariance register reloads state.
// Depends on skf_pkg, skf_mul and skf_div.
`default_nettype none

module scalar_kalman_filter_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [skf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [skf_pkg::DATA_W-1:0]        cfg_data,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [skf_pkg::DATA_W-1:0]        s_axis_tdata,  // measurement
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [skf_pkg::OUT_W-1:0]              m_axis_tdata   // estimate, covariance
);

	skf_pkg::state_t                   state_q, state_d;
	skf_pkg::step_t                    step_q;

	logic signed [skf_pkg::DATA_W-1:0] a_q, b_q, u_q, c_q;
	logic [skf_pkg::COV_W-1:0]         q_q, r_q;
	logic signed [skf_pkg::DATA_W-1:0] est_q;
	logic [skf_pkg::COV_W-1:0]         cov_q;

	logic signed [skf_pkg::DATA_W-1:0] z_q, xp_q, t_q, pp_q, num_q, cpp_q, den_q;
	logic signed [skf_pkg::DATA_W-1:0] y_q, inn_q, g_q;
	logic [skf_pkg::M_W-1:0]           part_q;

	logic signed [skf_pkg::DATA_W-1:0] out_est_q;
	logic [skf_pkg::COV_W-1:0]         out_cov_q;
	logic                              out_valid_q;

	logic                              accept;
	logic                              mul_start, div_start, out_load;
	logic                              mul_done, div_done;
	logic [skf_pkg::PROD_W-1:0]        mul_prod;
	logic signed [skf_pkg::DATA_W-1:0] gain;
	logic signed [skf_pkg::DATA_W-1:0] op_a, op_b;
	logic signed [skf_pkg::PROD_W-1:0] m, sum_v;
	logic signed [skf_pkg::DATA_W-1:0] m_sat, res;

	assign accept = s_axis_tvalid && s_axis_tready;

	skf_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (op_a),
		.b      (op_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	skf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.quo    (gain)
	);

	// operand select per step
	always_comb begin
		unique case (step_q)
			skf_pkg::STEP_AX:  begin op_a = a_q;   op_b = est_q;          end
			skf_pkg::STEP_BU:  begin op_a = b_q;   op_b = u_q;            end
			skf_pkg::STEP_AP:  begin op_a = a_q;   op_b = {1'b0, cov_q};  end
			skf_pkg::STEP_TA:  begin op_a = t_q;   op_b = a_q;            end
			skf_pkg::STEP_PC:  begin op_a = pp_q;  op_b = c_q;            end
			skf_pkg::STEP_CP:  begin op_a = c_q;   op_b = pp_q;           end
			skf_pkg::STEP_CPC: begin op_a = cpp_q; op_b = c_q;            end
			skf_pkg::STEP_CZ:  begin op_a = c_q;   op_b = z_q;            end
			skf_pkg::STEP_CX:  begin op_a = c_q;   op_b = xp_q;           end
			skf_pkg::STEP_KI:  begin op_a = gain;  op_b = inn_q;          end
			skf_pkg::STEP_KC:  begin op_a = gain;  op_b = c_q;            end
			skf_pkg::STEP_GP:  begin op_a = g_q;   op_b = pp_q;           end
			default:           begin op_a = '0;    op_b = '0;             end
		endcase
	end

	// rounded product, then the sum that follows it
	always_comb begin
		m     = $signed(mul_prod) >>> skf_pkg::FRAC_BITS;
		m_sat = skf_pkg::sat32(m);
		case (step_q)
			skf_pkg::STEP_BU:  sum_v = {{skf_pkg::FRAC_BITS{part_q[skf_pkg::M_W-1]}}, part_q} + m;
			skf_pkg::STEP_TA:  sum_v = m + {{(skf_pkg::PROD_W - skf_pkg::COV_W){1'b0}}, q_q};
			skf_pkg::STEP_CPC: sum_v = m + {{(skf_pkg::PROD_W - skf_pkg::COV_W){1'b0}}, r_q};
			skf_pkg::STEP_CX:  sum_v = skf_pkg::sext(y_q) - skf_pkg::sext(m_sat);
			skf_pkg::STEP_KI:  sum_v = skf_pkg::sext(xp_q) + m;
			skf_pkg::STEP_KC:  sum_v = skf_pkg::ONE_P - m;
			default:           sum_v = m;
		endcase
		res = skf_pkg::sat32(sum_v);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			skf_pkg::ST_IDLE:   if (s_axis_tvalid) state_d = skf_pkg::ST_MSTART;
			skf_pkg::ST_MSTART: state_d = skf_pkg::ST_MWAIT;
			skf_pkg::ST_MWAIT:  if (mul_done) state_d = skf_pkg::ST_COMB;
			skf_pkg::ST_COMB: begin
				if (step_q == skf_pkg::STEP_CPC) begin
					state_d = skf_pkg::ST_DSTART;
				end else if (step_q == skf_pkg::STEP_GP) begin
					state_d = skf_pkg::ST_DONE;
				end else begin
					state_d = skf_pkg::ST_MSTART;
				end
			end
			skf_pkg::ST_DSTART: state_d = skf_pkg::ST_DWAIT;
			skf_pkg::ST_DWAIT:  if (div_done) state_d = skf_pkg::ST_MSTART;
			skf_pkg::ST_DONE:   if (!out_valid_q || m_axis_tready) state_d = skf_pkg::ST_IDLE;
			default:            state_d = skf_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = (state_q == skf_pkg::ST_IDLE);
		mul_start     = (state_q == skf_pkg::ST_MSTART);
		div_start     = (state_q == skf_pkg::ST_DSTART);
		out_load      = (state_q == skf_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skf_pkg::ST_IDLE;
			step_q      <= skf_pkg::STEP_AX;
			out_valid_q <= 1'b0;
			a_q         <= skf_pkg::RST_TRANSITION;
			b_q         <= skf_pkg::RST_CONTROL;
			u_q         <= skf_pkg::RST_INPUT;
			q_q         <= skf_pkg::RST_PROC_NOISE;
			c_q         <= skf_pkg::RST_OBSERVATION;
			r_q         <= skf_pkg::RST_MEAS_NOISE;
			est_q       <= skf_pkg::RST_ESTIMATE;
			cov_q       <= skf_pkg::RST_COVARIANCE;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= skf_pkg::STEP_AX;
			end else if (state_q == skf_pkg::ST_COMB && step_q != skf_pkg::STEP_GP) begin
				step_q <= skf_pkg::step_t'(step_q + 4'd1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == skf_pkg::ST_COMB && step_q == skf_pkg::STEP_KI) begin
				est_q <= res;
			end
			if (state_q == skf_pkg::ST_COMB && step_q == skf_pkg::STEP_GP) begin
				cov_q <= m_sat[skf_pkg::DATA_W-1] ? '0 : m_sat[skf_pkg::COV_W-1:0];
			end
			if (cfg_we) begin
				unique case (skf_pkg::cfg_reg_t'(cfg_index))
					skf_pkg::REG_TRANSITION:  a_q   <= cfg_data;
					skf_pkg::REG_CONTROL:     b_q   <= cfg_data;
					skf_pkg::REG_INPUT:       u_q   <= cfg_data;
					skf_pkg::REG_PROC_NOISE:  q_q   <= cfg_data[skf_pkg::COV_W-1:0];
					skf_pkg::REG_OBSERVATION: c_q   <= cfg_data;
					skf_pkg::REG_MEAS_NOISE:  r_q   <= cfg_data[skf_pkg::COV_W-1:0];
					skf_pkg::REG_INIT_EST:    est_q <= cfg_data;
					skf_pkg::REG_INIT_COV:    cov_q <= cfg_data[skf_pkg::COV_W-1:0];
					default:                  ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			z_q <= s_axis_tdata;
		end
		if (state_q == skf_pkg::ST_COMB) begin
			case (step_q)
				skf_pkg::STEP_AX:  part_q <= m[skf_pkg::M_W-1:0];
				skf_pkg::STEP_BU:  xp_q   <= res;
				skf_pkg::STEP_AP:  t_q    <= res;
				skf_pkg::STEP_TA:  pp_q   <= res;
				skf_pkg::STEP_PC:  num_q  <= res;
				skf_pkg::STEP_CP:  cpp_q  <= res;
				skf_pkg::STEP_CPC: den_q  <= res;
				skf_pkg::STEP_CZ:  y_q    <= res;
				skf_pkg::STEP_CX:  inn_q  <= res;
				skf_pkg::STEP_KC:  g_q    <= res;
				default:           ;
			endcase
		end
		if (out_load) begin
			out_est_q <= est_q;
			out_cov_q <= cov_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(skf_pkg::OUT_W - skf_pkg::DATA_W - skf_pkg::COV_W){1'b0}},
		out_cov_q, out_est_q};

endmodule

`default_nettype wire

// ===== rtl/skf_chk.sv =====
// port-level checks for the scalar kalman filter unit
// bound to the top level below; uses skf_pkg
`default_nettype none

module skf_chk (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         s_axis_tvalid,
	input wire logic                         s_axis_tready,
	input wire logic                         m_axis_tvalid,
	input wire logic                         m_axis_tready,
	input wire logic [skf_pkg::OUT_W-1:0]    m_axis_tdata
);

	// one word in flight: no new word right after a take
	a_busy_next: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken again right after a word");

	a_busy_later: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> ##2 !s_axis_tready)
		else $error("input ready too soon after a word");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[skf_pkg::OUT_W-1])
		else $error("padding bit of output word set");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("output word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("output word changed while stalled");

endmodule

bind scalar_kalman_filter_unit skf_chk u_chk (.*);

`default_nettype wire
